/* rtl/slmt_pkg.sv */
// Shared types, constants and helper functions for the slime chunk MT19937 test core.
package slmt_pkg;

	localparam int unsigned MID_WORD = 397;
	localparam int unsigned IDX_W    = 9;

	localparam logic [31:0] SEED_MUL   = 32'h1F1F1F1F;
	localparam logic [31:0] INIT_MUL   = 32'd1812433253;
	localparam logic [31:0] TWIST_XOR  = 32'h9908B0DF;
	localparam logic [31:0] TEMPER_B   = 32'h9D2C5680;
	localparam logic [31:0] TEMPER_C   = 32'hEFC60000;
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

	typedef struct packed {
		logic signed [31:0] chunk_x;
		logic signed [31:0] chunk_z;
	} slmt_item_t;

	typedef struct packed {
		logic [31:0] first_draw;
		logic        is_slime;
	} slmt_result_t;

	// w: current recurrence word; y: upper bit of word 0 joined with the low bits of word 1
	typedef struct packed {
		logic [31:0] w;
		logic [31:0] y;
	} slmt_stage_t;

	function automatic logic [31:0] slmt_temper(input logic [31:0] v);
		logic [31:0] r;
		r = v ^ (v >> 11);
		r = r ^ ((r << 7) & TEMPER_B);
		r = r ^ ((r << 15) & TEMPER_C);
		r = r ^ (r >> 18);
		return r;
	endfunction

	// Multiple of 10: even, and nibble sum (16 = 1 mod 5) folded to a multiple of 5
	function automatic logic slmt_mult10(input logic [31:0] v);
		logic [6:0] s;
		logic [4:0] f1;
		logic [4:0] f2;
		s = 7'd0;
		for (int k = 0; k < 8; k++) begin
			s = s + 7'(v[4*k +: 4]);
		end
		f1 = 5'(s[3:0]) + 5'(s[6:4]);
		f2 = 5'(f1[3:0]) + 5'(f1[4]);
		return !v[0] && (f2 == 5'd0 || f2 == 5'd5 || f2 == 5'd10 || f2 == 5'd15);
	endfunction

endpackage

/* rtl/slime_chunk_mt19937_test_core.sv */
// Top level of the slime chunk test: chunk coordinates in, first MT19937 draw and flag out.
//
// Each accepted item (chunk_x, chunk_z) yields exactly one result, in order. The seed
// (chunk_x * 0x1F1F1F1F) ^ chunk_z enters a fixed pipeline of 400 register stages: one seed
// stage, 397 stages of the MT19937 initialization recurrence (one 32x32 multiply each, words
// 1 through 397), one twist-and-temper stage and the output register, where the mod-10 flag
// is formed. The accepting edge loads the seed stage, and the block takes one item per cycle
// unless it stalls. All stages share one advance enable: the pipeline moves whenever the last
// internal stage is empty, the output register is empty, or the output item is being taken,
// so new items keep entering while a finished result waits as long as no result is queued
// behind it. Nothing is kept between items and no reset sweep is needed.
module slime_chunk_mt19937_test_core import slmt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  slmt_item_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output slmt_result_t result
);

	logic        en;
	logic        seed_valid;
	slmt_stage_t seed_data;
	logic        chain_valid [0:MID_WORD];
	slmt_stage_t chain_data  [0:MID_WORD];
	logic        last_valid;
	logic [31:0] last_draw;
	logic        out_valid_q;
	slmt_result_t out_q;

	// advance everything unless a finished draw is blocked behind an untaken result
	assign en         = !last_valid || !out_valid_q || result_ready;
	assign item_ready = en;

	slmt_seed u_seed (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (item_valid),
		.item_in  (item),
		.valid_s1 (seed_valid),
		.data_s1  (seed_data)
	);

	assign chain_valid[0] = seed_valid;
	assign chain_data[0]  = seed_data;

	// one recurrence step per stage, word index tied per instance
	for (genvar g = 0; g < MID_WORD; g++) begin : g_step
		slmt_init_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.idx      (IDX_W'(g + 1)),
			.valid_in (chain_valid[g]),
			.data_in  (chain_data[g]),
			.valid_s1 (chain_valid[g+1]),
			.data_s1  (chain_data[g+1])
		);
	end

	slmt_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (chain_valid[MID_WORD]),
		.data_in  (chain_data[MID_WORD]),
		.valid_s1 (last_valid),
		.draw_s1  (last_draw)
	);

	// output register: drop the item when taken, load the next draw when it arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (en && last_valid) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && last_valid) begin
			out_q.first_draw <= last_draw;
			out_q.is_slime   <= slmt_mult10(last_draw);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef NO_ASSERTIONS
	// a stall only happens with a draw queued behind an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (last_valid && result_valid && !result_ready))
		else $error("pipeline stalled without a blocked result");

	// an accepted item shows up in the seed stage next cycle
	a_seed_load: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> seed_valid)
		else $error("accepted item missing from seed stage");

	// an odd draw is never flagged
	a_flag_even: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.is_slime) |-> !result.first_draw[0])
		else $error("odd draw flagged as multiple of ten");

	// a finished draw is not overwritten while the result waits
	a_hold_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(last_valid && result_valid && !result_ready) |=> (last_valid && $stable(last_draw)))
		else $error("finished draw lost during stall");
`endif

endmodule

/* rtl/slmt_seed.sv */
// Seed stage: mixes the chunk coordinates into MT word 0.
module slmt_seed import slmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_in,
	input  slmt_item_t  item_in,
	output logic        valid_s1,
	output slmt_stage_t data_s1
);

	logic [63:0] prod;
	logic [31:0] w0;

	assign prod = 64'(unsigned'(item_in.chunk_x)) * 64'(SEED_MUL);
	assign w0   = prod[31:0] ^ unsigned'(item_in.chunk_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.w <= w0;
			data_s1.y <= w0;
		end
	end

endmodule

/* rtl/slmt_init_step.sv */
// One registered step of the MT19937 initialization recurrence.
module slmt_init_step import slmt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] idx,
	input  logic             valid_in,
	input  slmt_stage_t      data_in,
	output logic             valid_s1,
	output slmt_stage_t      data_s1
);

	logic [31:0] t;
	logic [63:0] prod;
	logic [31:0] w_next;

	assign t      = data_in.w ^ (data_in.w >> 30);
	assign prod   = 64'(t) * 64'(INIT_MUL);
	assign w_next = prod[31:0] + 32'(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.w <= w_next;
			// capture the twist operand once word 1 is known
			if (idx == FIRST_IDX) begin
				data_s1.y <= {data_in.w[31], w_next[30:0]};
			end else begin
				data_s1.y <= data_in.y;
			end
		end
	end

endmodule

/* rtl/slmt_finish.sv */
// Twist and tempering stage: builds the first MT output word.
module slmt_finish import slmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_in,
	input  slmt_stage_t data_in,
	output logic        valid_s1,
	output logic [31:0] draw_s1
);

	logic [31:0] twisted;

	assign twisted = data_in.w ^ (data_in.y >> 1) ^ (data_in.y[0] ? TWIST_XOR : 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			draw_s1 <= slmt_temper(twisted);
		end
	end

endmodule
